// ----- rtl/cpq_pkg.sv -----
`default_nettype none
package cpq_pkg;

   // default sizes handed to the top level
   localparam int DEF_MAX_ENTRIES = 16;
   localparam int DEF_TIME_BITS   = 32;
   localparam int DEF_ID_BITS     = 16;

   // capacity register
   localparam int              CAP_BITS  = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   // operation codes
   localparam logic FUNC_PUT = 1'b0;
   localparam logic FUNC_GET = 1'b1;

   // per-cycle command broadcast along the chain
   typedef struct packed {
      logic put;
      logic get;
   } cmd_type;

endpackage
`default_nettype wire

// ----- rtl/cpq_cell.sv -----
`default_nettype none
module cpq_cell #(
   parameter int INDEX     = 0,
   parameter int CNT_BITS  = 5,
   parameter int TIME_BITS = 32,
   parameter int ID_BITS   = 16
) (
   input  wire                     clock,
   input  wire  cpq_pkg::cmd_type  cmd,
   input  wire  [CNT_BITS-1:0]     count,
   input  wire  [TIME_BITS-1:0]    new_end,
   input  wire  [ID_BITS-1:0]      new_id,
   input  wire                     left_gt,
   input  wire  [TIME_BITS-1:0]    left_end,
   input  wire  [ID_BITS-1:0]      left_id,
   input  wire  [TIME_BITS-1:0]    right_end,
   input  wire  [ID_BITS-1:0]      right_id,
   output logic                    gt_out,
   output logic [TIME_BITS-1:0]    end_out,
   output logic [ID_BITS-1:0]      id_out,
   output logic [TIME_BITS-1:0]    end_next
);
   import cpq_pkg::*;

   localparam logic [CNT_BITS-1:0] IDX = CNT_BITS'(INDEX);

   logic [TIME_BITS-1:0] end_ff, end_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic                 occupied, tail, gt, own_gt;

   // position of this cell relative to the fill level
   assign occupied = IDX < count;
   assign tail     = IDX == count;
   assign gt       = end_ff > new_end;
   assign own_gt   = occupied ? gt : tail;
   assign gt_out   = occupied & gt;

   // insert shifts right behind the new entry, removal shifts left
   always_comb begin
      end_in = end_ff;
      id_in  = id_ff;
      if (cmd.put) begin
         if (left_gt) begin
            end_in = left_end;
            id_in  = left_id;
         end else if (own_gt) begin
            end_in = new_end;
            id_in  = new_id;
         end
      end else if (cmd.get) begin
         end_in = right_end;
         id_in  = right_id;
      end
   end

   always_ff @(posedge clock) begin
      end_ff <= end_in;
      id_ff  <= id_in;
   end

   assign end_out  = end_ff;
   assign id_out   = id_ff;
   assign end_next = end_in;

endmodule
`default_nettype wire

// ----- rtl/cpq_chain.sv -----
`default_nettype none
module cpq_chain #(
   parameter int MAX_ENTRIES = 16,
   parameter int CNT_BITS    = 5,
   parameter int TIME_BITS   = 32,
   parameter int ID_BITS     = 16
) (
   input  wire                     clock,
   input  wire  cpq_pkg::cmd_type  cmd,
   input  wire  [CNT_BITS-1:0]     count,
   input  wire  [TIME_BITS-1:0]    new_end,
   input  wire  [ID_BITS-1:0]      new_id,
   output logic [TIME_BITS-1:0]    head_end,
   output logic [ID_BITS-1:0]      head_id,
   output logic [TIME_BITS-1:0]    head_end_next
);
   import cpq_pkg::*;

   logic [MAX_ENTRIES-1:0] gt_link;
   logic [TIME_BITS-1:0]   end_link [MAX_ENTRIES+1];
   logic [ID_BITS-1:0]     id_link  [MAX_ENTRIES+1];
   logic [TIME_BITS-1:0]   end_next [MAX_ENTRIES];
   logic [TIME_BITS-1:0]   left_end [MAX_ENTRIES];
   logic [ID_BITS-1:0]     left_id  [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] left_gt;

   // the far end of the chain feeds nothing useful on removal
   assign end_link[MAX_ENTRIES] = '0;
   assign id_link[MAX_ENTRIES]  = '0;

   // row of cells, each talking to its two neighbours
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_gt[i]  = 1'b0;
         assign left_end[i] = '0;
         assign left_id[i]  = '0;
      end else begin : g_rest
         assign left_gt[i]  = gt_link[i-1];
         assign left_end[i] = end_link[i-1];
         assign left_id[i]  = id_link[i-1];
      end

      cpq_cell #(
         .INDEX     (i),
         .CNT_BITS  (CNT_BITS),
         .TIME_BITS (TIME_BITS),
         .ID_BITS   (ID_BITS)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .count     (count),
         .new_end   (new_end),
         .new_id    (new_id),
         .left_gt   (left_gt[i]),
         .left_end  (left_end[i]),
         .left_id   (left_id[i]),
         .right_end (end_link[i+1]),
         .right_id  (id_link[i+1]),
         .gt_out    (gt_link[i]),
         .end_out   (end_link[i]),
         .id_out    (id_link[i]),
         .end_next  (end_next[i])
      );
   end

   assign head_end      = end_link[0];
   assign head_id       = id_link[0];
   assign head_end_next = end_next[0];

endmodule
`default_nettype wire

// ----- rtl/completion_time_priority_queue.sv -----
`default_nettype none
// channel  direction  transfer when        payload
// req_     in         valid & !stall       func, now_time, entry_id, service_time
// rsp_     out        valid & !stall       done_res, out_id, out_end_time, held_count,
//                                          next_end_valid, next_end_time
// csr_     in         write_enable         pool_capacity
//
// one item per cycle: the whole sorted chain updates in the cycle the request
// transfers, and the result appears in the response register on the next cycle.
// the rate is set by the single response register: a request is taken only
// while that register is empty or being drained.
// reset clears the fill count, the response valid and sets capacity to 16;
// cell contents are left as they are, only filled cells are ever read.
module completion_time_priority_queue #(
   parameter int MAX_ENTRIES = cpq_pkg::DEF_MAX_ENTRIES,
   parameter int TIME_BITS   = cpq_pkg::DEF_TIME_BITS,
   parameter int ID_BITS     = cpq_pkg::DEF_ID_BITS,
   parameter int CNT_BITS    = $clog2(MAX_ENTRIES + 1)
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire                            req_func,
   input  wire  [TIME_BITS-1:0]           req_now_time,
   input  wire  [ID_BITS-1:0]             req_entry_id,
   input  wire  [TIME_BITS-1:0]           req_service_time,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic                           rsp_done_res,
   output logic [ID_BITS-1:0]             rsp_out_id,
   output logic [TIME_BITS-1:0]           rsp_out_end_time,
   output logic [CNT_BITS-1:0]            rsp_held_count,
   output logic                           rsp_next_end_valid,
   output logic [TIME_BITS-1:0]           rsp_next_end_time,
   input  wire                            csr_write_enable,
   input  wire  [cpq_pkg::CAP_BITS-1:0]   csr_write_data
);
   import cpq_pkg::*;

   localparam int CMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;
   localparam logic [CMP_BITS-1:0] MAX_CMP = CMP_BITS'(MAX_ENTRIES);

   logic [CAP_BITS-1:0]  cap_ff;
   logic [CNT_BITS-1:0]  occ_ff, occ_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 done_ff, done_in;
   logic [ID_BITS-1:0]   oid_ff, oid_in;
   logic [TIME_BITS-1:0] oend_ff, oend_in;
   logic [CNT_BITS-1:0]  held_ff;
   logic                 nvalid_ff, nvalid_in;
   logic [TIME_BITS-1:0] nend_ff, nend_in;

   logic                 accept;
   logic [TIME_BITS:0]   sum;
   logic [TIME_BITS-1:0] new_end;
   logic [CMP_BITS-1:0]  occ_cmp, cap_cmp, limit;
   logic                 put_ok, get_ok;
   cmd_type              cmd;
   logic [TIME_BITS-1:0] head_end, head_end_next;
   logic [ID_BITS-1:0]   head_id;

   // request side waits only while a result is stuck in the output register
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // saturating end time
   assign sum     = {1'b0, req_now_time} + {1'b0, req_service_time};
   assign new_end = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

   // capacity clipped to the chain length
   assign occ_cmp = CMP_BITS'(occ_ff);
   assign cap_cmp = CMP_BITS'(cap_ff);
   assign limit   = (cap_cmp > MAX_CMP) ? MAX_CMP : cap_cmp;

   assign put_ok = accept & (req_func == FUNC_PUT) & (occ_cmp < limit);
   assign get_ok = accept & (req_func == FUNC_GET) & (occ_ff != '0)
                   & (head_end <= req_now_time);

   assign cmd.put = put_ok;
   assign cmd.get = get_ok;

   cpq_chain #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .CNT_BITS    (CNT_BITS),
      .TIME_BITS   (TIME_BITS),
      .ID_BITS     (ID_BITS)
   ) u_chain (
      .clock         (clock),
      .cmd           (cmd),
      .count         (occ_ff),
      .new_end       (new_end),
      .new_id        (req_entry_id),
      .head_end      (head_end),
      .head_id       (head_id),
      .head_end_next (head_end_next)
   );

   // fill count and result fields
   always_comb begin
      occ_in = occ_ff;
      if (put_ok) begin
         occ_in = occ_ff + CNT_BITS'(1);
      end else if (get_ok) begin
         occ_in = occ_ff - CNT_BITS'(1);
      end
      done_in   = put_ok | get_ok;
      oid_in    = get_ok ? head_id : '0;
      oend_in   = get_ok ? head_end : '0;
      nvalid_in = occ_in != '0;
      nend_in   = nvalid_in ? head_end_next : '0;
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         done_ff   <= done_in;
         oid_ff    <= oid_in;
         oend_ff   <= oend_in;
         held_ff   <= occ_in;
         nvalid_ff <= nvalid_in;
         nend_ff   <= nend_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_done_res       = done_ff;
   assign rsp_out_id         = oid_ff;
   assign rsp_out_end_time   = oend_ff;
   assign rsp_held_count     = held_ff;
   assign rsp_next_end_valid = nvalid_ff;
   assign rsp_next_end_time  = nend_ff;

endmodule
`default_nettype wire
